@@ rtl/core/fac_pkg.sv @@
// ============================================================================
// fac_pkg
// Shared types and constants for the frustum box culling block.
// ============================================================================
package fac_pkg;

    localparam int NUM_PLANES_DEF  = 6;
    localparam int COORD_WIDTH_DEF = 32;

    // field widths fixed by the interface
    localparam int FIELD_W = 32;
    localparam int PIDX_PORT_W = 3;

    // Q16.16: offset term is aligned to the product's Q32.32 point
    localparam int FRAC_BITS = 16;

    // action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TEST = 1'b1;

    typedef struct packed {
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        logic [FIELD_W-1:0] c;
        logic [FIELD_W-1:0] d;
    } plane_row_t;

    // sequencer to multiply-accumulate unit
    typedef struct packed {
        logic load_d;   // seed accumulator with the offset term
        logic mul_en;   // register a new product
        logic acc_en;   // fold the held product into the accumulator
    } mac_ctl_t;

endpackage

@@ rtl/core/fac_plane_store.sv @@
// ============================================================================
// fac_plane_store
// Plane coefficient table: one row (a, b, c, d) per plane, row write, row read.
// ============================================================================
module fac_plane_store
    import fac_pkg::*;
#(
    parameter int NUM_PLANES = NUM_PLANES_DEF,
    parameter int PIDX_W     = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [PIDX_W-1:0] wr_idx,
    input  plane_row_t        wr_row,
    input  logic [PIDX_W-1:0] rd_idx,
    output plane_row_t        rd_row
);

    plane_row_t rows_reg [NUM_PLANES];

    // contents are undefined until loaded; no reset
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rows_reg[wr_idx] <= wr_row;
        end
    end

    assign rd_row = rows_reg[rd_idx];

endmodule

@@ rtl/core/fac_mac.sv @@
// ============================================================================
// fac_mac
// Shared multiply-accumulate unit: picks the box corner per normal sign,
// one signed product per cycle while mul_en is set, exact wide distance accumulation.
// ============================================================================
module fac_mac
    import fac_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic               aclk,
    input  mac_ctl_t           ctl,
    input  logic [FIELD_W-1:0] coef_raw,
    input  logic [FIELD_W-1:0] lo_raw,
    input  logic [FIELD_W-1:0] hi_raw,
    input  logic [FIELD_W-1:0] d_raw,
    output logic               dist_neg
);

    localparam int CW    = COORD_WIDTH;
    localparam int PW    = 2 * CW;
    localparam int ACC_W = 2 * CW + 2;

    logic signed [CW-1:0]    coef_op;
    logic signed [CW-1:0]    lo_op;
    logic signed [CW-1:0]    hi_op;
    logic signed [CW-1:0]    d_op;
    logic signed [CW-1:0]    sel_op;
    logic                    coef_pos;
    logic signed [PW-1:0]    prod;
    logic signed [PW-1:0]    prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] d_ext;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] sum;

    // sign-extend from bit CW-1; wider operands see the field zero-extended
    if (CW <= FIELD_W) begin : g_narrow
        assign coef_op = coef_raw[CW-1:0];
        assign lo_op   = lo_raw[CW-1:0];
        assign hi_op   = hi_raw[CW-1:0];
        assign d_op    = d_raw[CW-1:0];
    end else begin : g_wide
        assign coef_op = {{(CW-FIELD_W){1'b0}}, coef_raw};
        assign lo_op   = {{(CW-FIELD_W){1'b0}}, lo_raw};
        assign hi_op   = {{(CW-FIELD_W){1'b0}}, hi_raw};
        assign d_op    = {{(CW-FIELD_W){1'b0}}, d_raw};
    end

    // zero component takes the minimum
    assign coef_pos = !coef_op[CW-1] && (coef_op != '0);
    assign sel_op   = coef_pos ? hi_op : lo_op;
    assign prod     = coef_op * sel_op;

    assign d_ext    = {{(ACC_W-CW-FRAC_BITS){d_op[CW-1]}}, d_op, {FRAC_BITS{1'b0}}};
    assign prod_ext = {{(ACC_W-PW){prod_reg[PW-1]}}, prod_reg};
    assign sum      = acc_reg + prod_ext;
    assign dist_neg = sum[ACC_W-1];

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= prod;
        end
        if (ctl.load_d) begin
            acc_reg <= d_ext;
        end else if (ctl.acc_en) begin
            acc_reg <= sum;
        end
    end

endmodule

@@ rtl/core/frustum_aabb_cull.sv @@
// ============================================================================
// frustum_aabb_cull
// Positive-vertex frustum test of axis-aligned boxes against a plane table.
// ============================================================================
// A load beat (action 0) writes one plane's a, b, c, d as one row; loads with
// an index at or above NUM_PLANES are dropped and give no result. A test beat
// (action 1) runs the planes in order through one shared multiplier, each
// plane as three products, then the final add and sign check. From its
// accept, a test holds off the next beat until its verdict has moved to the
// output register: a plane that culls the box ends the run early, and an
// earlier result that still waits holds the verdict back. The block accepts
// no beat while a test runs. One visible beat per test leaves through an
// output register, so a new beat is taken while the previous result waits.
module frustum_aabb_cull
    import fac_pkg::*;
#(
    parameter int NUM_PLANES  = NUM_PLANES_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_action,
    input  logic [PIDX_PORT_W-1:0] s_plane_index,
    input  logic [FIELD_W-1:0]     s_plane_a,
    input  logic [FIELD_W-1:0]     s_plane_b,
    input  logic [FIELD_W-1:0]     s_plane_c,
    input  logic [FIELD_W-1:0]     s_plane_d,
    input  logic [FIELD_W-1:0]     s_box_min_x,
    input  logic [FIELD_W-1:0]     s_box_min_y,
    input  logic [FIELD_W-1:0]     s_box_min_z,
    input  logic [FIELD_W-1:0]     s_box_max_x,
    input  logic [FIELD_W-1:0]     s_box_max_y,
    input  logic [FIELD_W-1:0]     s_box_max_z,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_visible
);

    localparam int PIDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam int CMP_W  = (PIDX_PORT_W > PIDX_W ? PIDX_PORT_W : PIDX_W) + 1;
    localparam logic [PIDX_W-1:0] LAST_PLANE = PIDX_W'(NUM_PLANES - 1);

    localparam logic [1:0] STEP_X    = 2'd0;
    localparam logic [1:0] STEP_Y    = 2'd1;
    localparam logic [1:0] STEP_Z    = 2'd2;
    localparam logic [1:0] STEP_SIGN = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          step_reg, step_next;
    logic [PIDX_W-1:0]   plane_reg, plane_next;
    logic                verdict_reg, verdict_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_visible_reg, m_visible_next;

    logic [FIELD_W-1:0]  min_x_reg, min_y_reg, min_z_reg;
    logic [FIELD_W-1:0]  max_x_reg, max_y_reg, max_z_reg;

    logic                accept;
    logic                load_en;
    logic                test_start;
    logic                out_free;
    plane_row_t          wr_row;
    plane_row_t          rd_row;
    mac_ctl_t            mac_ctl;
    logic [FIELD_W-1:0]  coef_raw, lo_raw, hi_raw;
    logic                dist_neg;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign load_en    = accept && (s_action == ACT_LOAD)
                        && (CMP_W'(s_plane_index) < CMP_W'(NUM_PLANES));
    assign test_start = accept && (s_action == ACT_TEST);
    assign out_free   = !m_valid_reg || m_ready;

    assign wr_row = '{a: s_plane_a, b: s_plane_b, c: s_plane_c, d: s_plane_d};

    fac_plane_store #(
        .NUM_PLANES (NUM_PLANES),
        .PIDX_W     (PIDX_W)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (load_en),
        .wr_idx (PIDX_W'(s_plane_index)),
        .wr_row (wr_row),
        .rd_idx (plane_reg),
        .rd_row (rd_row)
    );

    always_comb begin
        unique case (step_reg)
            STEP_X: begin
                coef_raw = rd_row.a; lo_raw = min_x_reg; hi_raw = max_x_reg;
            end
            STEP_Y: begin
                coef_raw = rd_row.b; lo_raw = min_y_reg; hi_raw = max_y_reg;
            end
            STEP_Z: begin
                coef_raw = rd_row.c; lo_raw = min_z_reg; hi_raw = max_z_reg;
            end
            default: begin
                coef_raw = rd_row.c; lo_raw = min_z_reg; hi_raw = max_z_reg;
            end
        endcase
    end

    always_comb begin
        mac_ctl.load_d = (state_reg == ST_RUN) && (step_reg == STEP_X);
        mac_ctl.mul_en = (state_reg == ST_RUN) && (step_reg != STEP_SIGN);
        mac_ctl.acc_en = (state_reg == ST_RUN)
                         && ((step_reg == STEP_Y) || (step_reg == STEP_Z));
    end

    fac_mac #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_mac (
        .aclk     (aclk),
        .ctl      (mac_ctl),
        .coef_raw (coef_raw),
        .lo_raw   (lo_raw),
        .hi_raw   (hi_raw),
        .d_raw    (rd_row.d),
        .dist_neg (dist_neg)
    );

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        plane_next     = plane_reg;
        verdict_next   = verdict_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_visible_next = m_visible_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (test_start) begin
                    state_next = ST_RUN;
                    step_next  = STEP_X;
                    plane_next = '0;
                end
            end
            ST_RUN: begin
                if (step_reg == STEP_SIGN) begin
                    step_next = STEP_X;
                    if (dist_neg) begin
                        verdict_next = 1'b0;
                        state_next   = ST_DONE;
                    end else if (plane_reg == LAST_PLANE) begin
                        verdict_next = 1'b1;
                        state_next   = ST_DONE;
                    end else begin
                        plane_next = plane_reg + 1'b1;
                    end
                end else begin
                    step_next = step_reg + 2'd1;
                end
            end
            ST_DONE: begin
                // hold the verdict until the output register is free
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_visible_next = verdict_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= STEP_X;
            plane_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            plane_reg   <= plane_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        verdict_reg   <= verdict_next;
        m_visible_reg <= m_visible_next;
        if (test_start) begin
            min_x_reg <= s_box_min_x;
            min_y_reg <= s_box_min_y;
            min_z_reg <= s_box_min_z;
            max_x_reg <= s_box_max_x;
            max_y_reg <= s_box_max_y;
            max_z_reg <= s_box_max_z;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_visible = m_visible_reg;

    a_plane_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (CMP_W'(plane_reg) < CMP_W'(NUM_PLANES)))
        else $error("plane counter out of range");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg || m_ready) && (state_reg != ST_DONE) |=> !m_valid_reg)
        else $error("result beat without a finished test");

    a_done_releases: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) && out_free |=> (state_reg == ST_IDLE) && m_valid_reg)
        else $error("finished test not handed to output");

    a_plane_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) && (step_reg == STEP_SIGN) && !dist_neg
        && (plane_reg != LAST_PLANE)
        |=> (state_reg == ST_RUN) && (step_reg == STEP_X)
            && (plane_reg == $past(plane_reg) + 1'b1))
        else $error("plane sequence broken");

endmodule

@@ dv/tb_frustum_aabb_cull.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_frustum_aabb_cull
// Self-checking bench for the positive-vertex box culling block.
// A directed table (plane loads, extreme boxes, dropped loads, zero distance)
// runs first, then random load/test traffic under four idling phases. Every
// visible beat is checked against a typed flag or a full-width plane-test predictor.
// ============================================================================
module tb_frustum_aabb_cull;
    import fac_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int N_RANDOM   = 1276;
    localparam int DRAIN_CYC  = 40;     // longer than one test keeps the block busy
    localparam int STALL_MAX  = 1000;   // cycles without any beat before giving up
    localparam int ACC_W      = 2*FIELD_W + 4;

    localparam logic [FIELD_W-1:0] Q_ZERO    = 32'h0000_0000;
    localparam logic [FIELD_W-1:0] Q_MIN     = 32'h8000_0000;
    localparam logic [FIELD_W-1:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [FIELD_W-1:0] Q_ONE     = 32'h0001_0000;
    localparam logic [FIELD_W-1:0] Q_NEG_ONE = 32'hFFFF_0000;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic                   action;
        logic [PIDX_PORT_W-1:0] pidx;
        logic [FIELD_W-1:0]     pa;
        logic [FIELD_W-1:0]     pb;
        logic [FIELD_W-1:0]     pc;
        logic [FIELD_W-1:0]     pd;
        logic [FIELD_W-1:0]     mnx;
        logic [FIELD_W-1:0]     mny;
        logic [FIELD_W-1:0]     mnz;
        logic [FIELD_W-1:0]     mxx;
        logic [FIELD_W-1:0]     mxy;
        logic [FIELD_W-1:0]     mxz;
        logic                   chk;    // take the expected flag typed in below
        logic                   vis;
        idle_mode_t             mode;
    } cull_beat_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic m_ready = 1'b0;
    logic s_ready;
    logic m_valid;
    logic m_visible;

    cull_beat_t drv_beat = '0;
    idle_mode_t cur_mode = IDLE_NONE;

    cull_beat_t beat_q[$];
    logic       vis_q[$];
    logic [FIELD_W-1:0] plane_mem [NUM_PLANES_DEF][4];

    int err_count   = 0;
    int result_cnt  = 0;
    int idle_cycles = 0;

    always #(CLK_PERIOD/2) aclk = ~aclk;

    frustum_aabb_cull u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (drv_beat.action),
        .s_plane_index (drv_beat.pidx),
        .s_plane_a     (drv_beat.pa),
        .s_plane_b     (drv_beat.pb),
        .s_plane_c     (drv_beat.pc),
        .s_plane_d     (drv_beat.pd),
        .s_box_min_x   (drv_beat.mnx),
        .s_box_min_y   (drv_beat.mny),
        .s_box_min_z   (drv_beat.mnz),
        .s_box_max_x   (drv_beat.mxx),
        .s_box_max_y   (drv_beat.mxy),
        .s_box_max_z   (drv_beat.mxz),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_visible     (m_visible)
    );

    // --------------------------------------------------------------------
    // predictor: positive-vertex distance per plane, kept exact at ACC_W bits
    // --------------------------------------------------------------------
    function automatic logic cull_visible(cull_beat_t t);
        logic [FIELD_W-1:0]      lo [3];
        logic [FIELD_W-1:0]      hi [3];
        logic signed [FIELD_W-1:0] n;
        logic signed [ACC_W-1:0] reach;
        logic signed [ACC_W-1:0] coef;
        logic signed [ACC_W-1:0] pt;
        logic                    seen;
        lo[0] = t.mnx; lo[1] = t.mny; lo[2] = t.mnz;
        hi[0] = t.mxx; hi[1] = t.mxy; hi[2] = t.mxz;
        seen = 1'b1;
        for (int p = 0; p < NUM_PLANES_DEF; p++) begin
            reach = $signed(plane_mem[p][3]);
            reach = reach <<< FRAC_BITS;
            for (int k = 0; k < 3; k++) begin
                n     = plane_mem[p][k];
                coef  = n;
                // zero component takes the minimum
                pt    = (n > 0) ? $signed(hi[k]) : $signed(lo[k]);
                reach = reach + coef * pt;
            end
            if (reach < 0) seen = 1'b0;
        end
        return seen;
    endfunction

    function automatic int idle_pct(idle_mode_t m, bit recv_side);
        case (m)
            IDLE_SEND: return recv_side ? 0 : 67;
            IDLE_RECV: return recv_side ? 67 : 0;
            IDLE_BOTH: return 19;
            default:   return 0;
        endcase
    endfunction

    // mix of extremes, small coordinates and full-range patterns
    function automatic logic [FIELD_W-1:0] rand_q();
        case ($urandom_range(7))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return Q_ZERO;
            3, 4, 5: return 32'($urandom_range(32'h000F_FFFF)) - 32'h0008_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic cull_beat_t plane_load(int idx, logic [FIELD_W-1:0] a,
                                              logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] c,
                                              logic [FIELD_W-1:0] d);
        cull_beat_t t;
        t        = '0;
        t.action = ACT_LOAD;
        t.pidx   = PIDX_PORT_W'(idx);
        t.pa = a; t.pb = b; t.pc = c; t.pd = d;
        t.mode   = IDLE_NONE;
        return t;
    endfunction

    function automatic cull_beat_t box_test(logic [FIELD_W-1:0] nx, logic [FIELD_W-1:0] ny,
                                            logic [FIELD_W-1:0] nz, logic [FIELD_W-1:0] xx,
                                            logic [FIELD_W-1:0] xy, logic [FIELD_W-1:0] xz,
                                            logic chk, logic vis);
        cull_beat_t t;
        t        = '0;
        t.action = ACT_TEST;
        t.mnx = nx; t.mny = ny; t.mnz = nz;
        t.mxx = xx; t.mxy = xy; t.mxz = xz;
        t.chk = chk; t.vis = vis;
        t.mode   = IDLE_NONE;
        return t;
    endfunction

    // --------------------------------------------------------------------
    // drivers
    // --------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= idle_pct(cur_mode, 1'b1));
            if (!s_valid || s_ready) begin
                if (beat_q.size() != 0 &&
                    $urandom_range(99) >= idle_pct(beat_q[0].mode, 1'b0)) begin
                    cur_mode = beat_q[0].mode;
                    drv_beat <= beat_q.pop_front();
                    s_valid  <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // --------------------------------------------------------------------
    // monitor and scoreboard
    // --------------------------------------------------------------------
    task automatic note_error(string what, logic want, logic got);
        err_count++;
        if (err_count <= 10)
            $display("[%0t] %s: result %0d expected visible=%0b got %0b",
                     $realtime, what, result_cnt, want, got);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((m_valid && m_ready) || (s_valid && s_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) begin
                if (vis_q.size() == 0) note_error("unexpected beat", 1'bx, m_visible);
                else if (m_visible !== vis_q[0]) note_error("mismatch", vis_q[0], m_visible);
                if (vis_q.size() != 0) void'(vis_q.pop_front());
                result_cnt++;
            end
            // result is checked first: an output beat always belongs to an older test
            if (s_valid && s_ready) begin
                if (drv_beat.action == ACT_LOAD) begin
                    if (drv_beat.pidx < NUM_PLANES_DEF) begin
                        plane_mem[drv_beat.pidx][0] = drv_beat.pa;
                        plane_mem[drv_beat.pidx][1] = drv_beat.pb;
                        plane_mem[drv_beat.pidx][2] = drv_beat.pc;
                        plane_mem[drv_beat.pidx][3] = drv_beat.pd;
                    end
                end else begin
                    vis_q.push_back(drv_beat.chk ? drv_beat.vis : cull_visible(drv_beat));
                end
            end
        end
    end

    initial begin
        while (idle_cycles < STALL_MAX) @(posedge aclk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // --------------------------------------------------------------------
    // stimulus
    // --------------------------------------------------------------------
    initial begin
        cull_beat_t directed [24];
        cull_beat_t b;

        for (int p = 0; p < NUM_PLANES_DEF; p++)
            for (int k = 0; k < 4; k++) plane_mem[p][k] = '0;

        directed = '{
            // every plane defined before the first test
            plane_load(0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO),
            plane_load(1, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO),
            plane_load(2, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO),
            plane_load(3, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO),
            plane_load(4, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO),
            plane_load(5, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO),
            box_test(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b1, 1'b1),
            // out-of-range indexes must be dropped
            plane_load(6, Q_MIN, Q_MIN, Q_MIN, Q_MIN),
            plane_load(7, Q_MIN, Q_MIN, Q_MIN, Q_MIN),
            box_test(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 1'b1, 1'b1),
            plane_load(0, Q_MAX, Q_ZERO, Q_ZERO, Q_MIN),
            box_test(Q_ZERO, Q_ZERO, Q_ZERO, Q_MAX, Q_ZERO, Q_ZERO, 1'b0, 1'b0),
            // swapped corners, positive a picks max_x = 0, leaving d < 0
            box_test(Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1, 1'b0),
            plane_load(0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO),
            // sum of three extreme products needs more than 64 bits
            plane_load(1, Q_MIN, Q_MIN, Q_MIN, Q_MAX),
            box_test(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b0, 1'b0),
            box_test(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 1'b0, 1'b0),
            // distance exactly zero, then one lsb short
            plane_load(1, Q_ONE, Q_ZERO, Q_ZERO, Q_NEG_ONE),
            box_test(Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, 1'b0, 1'b0),
            box_test(Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE - 1, Q_ZERO, Q_ZERO, 1'b0, 1'b0),
            plane_load(2, Q_ZERO, Q_ONE, Q_NEG_ONE, Q_ZERO),
            box_test(Q_MIN, Q_NEG_ONE, Q_ONE, Q_MAX, Q_ZERO, Q_MAX, 1'b0, 1'b0),
            box_test(Q_ZERO, Q_ONE, Q_NEG_ONE, Q_ZERO, Q_ONE, Q_ZERO, 1'b0, 1'b0),
            plane_load(5, 32'h0000_0001, 32'hFFFF_FFFF, Q_MAX, 32'h0000_0001)
        };
        foreach (directed[i]) beat_q.push_back(directed[i]);

        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(3) == 0) begin
                b = plane_load(($urandom_range(9) == 0) ? $urandom_range(7, 6)
                                                          : $urandom_range(5),
                               rand_q(), rand_q(), rand_q(), rand_q());
                if ($urandom_range(5) == 0) {b.pa, b.pb, b.pc, b.pd} = '0;
                {b.mnx, b.mny, b.mnz} = {$urandom(), $urandom(), $urandom()};
                {b.mxx, b.mxy, b.mxz} = {$urandom(), $urandom(), $urandom()};
            end else begin
                b = box_test(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                             1'b0, 1'b0);
                {b.pa, b.pb, b.pc, b.pd} = {$urandom(), $urandom(), $urandom(), $urandom()};
                b.pidx = PIDX_PORT_W'($urandom());
                // most boxes well formed, the rest keep corners as drawn
                if ($urandom_range(3) != 0) begin
                    if ($signed(b.mnx) > $signed(b.mxx)) {b.mnx, b.mxx} = {b.mxx, b.mnx};
                    if ($signed(b.mny) > $signed(b.mxy)) {b.mny, b.mxy} = {b.mxy, b.mny};
                    if ($signed(b.mnz) > $signed(b.mxz)) {b.mnz, b.mxz} = {b.mxz, b.mnz};
                end
            end
            b.mode = idle_mode_t'((i * 4) / N_RANDOM);
            beat_q.push_back(b);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (beat_q.size() != 0 || s_valid || vis_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        err_count += vis_q.size();

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
